/* hw/rtl/pphe_pkg.sv */
// Shared types and constants for the parallel port handshake engine.
// No dependencies; imported by every module of the engine.
`timescale 1ns / 1ps
`default_nettype none

package pphe_pkg;

    // Configuration register width and indexes
    localparam int CFG_W       = 24;
    localparam int CFG_ADDR_W  = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WRITE_TIMEOUT = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_READ_TIMEOUT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_INIT_PULSE    = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_INIT_RECOVER  = 2'd3;
    localparam logic [CFG_W-1:0] CFG_INIT_PULSE_RST   = 24'd100;
    localparam logic [CFG_W-1:0] CFG_INIT_RECOVER_RST = 24'd100;

    // Stream widths
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    // Command queue between front and back
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCOUNT_W = 3;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_RESET = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ERR_OK         = 2'd0,
        ERR_WRITE_TIME = 2'd1,
        ERR_READ_TIME  = 2'd2
    } t_err;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_W_NOTBUSY = 4'd1,
        PH_W_BUSY    = 4'd2,
        PH_W_CLEAR   = 4'd3,
        PH_R_NOTBUSY = 4'd4,
        PH_R_ACK     = 4'd5,
        PH_R_ACKOFF  = 4'd6,
        PH_I_PULSE   = 4'd7,
        PH_I_RECOVER = 4'd8
    } t_phase;

    // One decoded tick as it travels through the queue
    typedef struct packed {
        t_op        op;
        logic [7:0] byte_to_send;
        logic       first_of_buffer;
        logic       busy_off;
        logic       ack_off;
        logic [7:0] data_lines_in;
    } t_cmd;

    // Result beat, packed so that strobe_on lands in bit 0
    typedef struct packed {
        logic [7:0] received_byte;
        t_err       error_code;
        logic       done_res;
        logic       engine_busy;
        logic       lines_are_input;
        logic [7:0] data_lines_out;
        logic       init_on;
        logic       autofd_on;
        logic       strobe_on;
    } t_result;

    // Configuration write strobe group
    typedef struct packed {
        logic                  we;
        logic [CFG_ADDR_W-1:0] addr;
        logic [CFG_W-1:0]      data;
    } t_cfg_wr;

endpackage

`default_nettype wire

/* hw/rtl/pphe_front.sv */
// Front stage: takes input beats, unpacks and classifies them into commands.
// Depends on pphe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pphe_front
    import pphe_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [IN_DATA_W-1:0] i_data,
    input  wire logic [IN_USER_W-1:0] i_user,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output t_cmd                      o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    // Unpack the fields of the input beat; the status bits are copied as they are
    always_comb begin
        n_cmd.op              = t_op'(i_user);
        n_cmd.byte_to_send    = i_data[7:0];
        n_cmd.first_of_buffer = i_data[8];
        n_cmd.busy_off        = i_data[9];
        n_cmd.ack_off         = i_data[10];
        n_cmd.data_lines_in   = i_data[18:11];
    end

    // Take a new beat whenever the stage is empty or drains this cycle
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Hold the command register while stalled
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

endmodule

`default_nettype wire

/* hw/rtl/pphe_queue.sv */
// Short command queue that decouples the front stage from the handshake engine.
// Depends on pphe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pphe_queue
    import pphe_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push_valid,
    output logic      o_push_ready,
    input  t_cmd      i_push_cmd,
    output logic      o_pop_valid,
    input  wire logic i_pop_ready,
    output t_cmd      o_pop_cmd
);

    t_cmd                r_slot [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCOUNT_W-1:0] r_count;
    logic                push;
    logic                pop;

    assign o_push_ready = (r_count != QCOUNT_W'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop_ready && o_pop_valid;
    assign o_pop_cmd    = r_slot[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCOUNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCOUNT_W'(1);
            end
        end
    end

    // Store the pushed command
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pphe_back.sv */
// Back end: handshake state machine, buffer timer, config registers, result register.
// Depends on pphe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pphe_back
    import pphe_pkg::*;
#(
    parameter int TIMER_WIDTH = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cfg_wr   i_cfg,
    input  wire logic i_cmd_valid,
    output logic      o_cmd_ready,
    input  t_cmd      i_cmd,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_result   o_out
);

    logic [CFG_W-1:0]       r_write_timeout;
    logic [CFG_W-1:0]       r_read_timeout;
    logic [CFG_W-1:0]       r_init_pulse;
    logic [CFG_W-1:0]       r_init_recover;

    t_phase                 r_phase;
    t_phase                 n_phase;
    logic [TIMER_WIDTH-1:0] r_ticks;
    logic [TIMER_WIDTH-1:0] n_ticks;
    logic                   r_expired;
    logic                   n_expired;
    logic [7:0]             r_held_byte;
    logic [7:0]             n_held_byte;
    logic [7:0]             r_latched_byte;
    logic [7:0]             n_latched_byte;
    logic                   done;
    t_err                   err;
    logic                   in_reset;
    logic                   step;
    logic                   r_out_valid;
    t_result                r_out;
    t_result                n_out;

    // Mask a register value to the timer width
    function automatic logic [TIMER_WIDTH-1:0] tmask(input logic [CFG_W-1:0] v);
        logic [31:0] ext;
        ext = 32'(v);
        return ext[TIMER_WIDTH-1:0];
    endfunction

    // Counter load for a duration: zero and one both give a single tick
    function automatic logic [TIMER_WIDTH-1:0] count_load(input logic [CFG_W-1:0] v);
        logic [TIMER_WIDTH-1:0] m;
        m = tmask(v);
        return (m == '0) ? '0 : m - TIMER_WIDTH'(1);
    endfunction

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_timeout <= '0;
            r_read_timeout  <= '0;
            r_init_pulse    <= CFG_INIT_PULSE_RST;
            r_init_recover  <= CFG_INIT_RECOVER_RST;
        end else if (i_cfg.we) begin
            unique case (i_cfg.addr)
                CFG_WRITE_TIMEOUT: r_write_timeout <= i_cfg.data;
                CFG_READ_TIMEOUT:  r_read_timeout  <= i_cfg.data;
                CFG_INIT_PULSE:    r_init_pulse    <= i_cfg.data;
                CFG_INIT_RECOVER:  r_init_recover  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Run one tick whenever a command waits and the result slot frees up
    assign step        = i_cmd_valid && (!r_out_valid || i_out_ready);
    assign o_cmd_ready = step;
    assign in_reset    = (r_phase == PH_I_PULSE) || (r_phase == PH_I_RECOVER);

    // Next state: timer, command start, reset sequencing, then one wait step
    always_comb begin
        n_phase        = r_phase;
        n_ticks        = r_ticks;
        n_expired      = r_expired;
        n_held_byte    = r_held_byte;
        n_latched_byte = r_latched_byte;
        done           = 1'b0;
        err            = ERR_OK;

        // Count the buffer timer down outside a printer reset
        if (!in_reset && r_ticks != '0) begin
            n_ticks = r_ticks - TIMER_WIDTH'(1);
            if (n_ticks == '0) begin
                n_expired = 1'b1;
            end
        end

        if (r_phase == PH_IDLE && i_cmd.op != OP_TICK) begin
            if (i_cmd.op == OP_RESET) begin
                n_phase   = PH_I_PULSE;
                n_expired = 1'b0;
                n_ticks   = count_load(r_init_pulse);
            end else begin
                if (i_cmd.first_of_buffer) begin
                    n_ticks   = tmask((i_cmd.op == OP_WRITE) ? r_write_timeout
                                                              : r_read_timeout);
                    n_expired = 1'b0;
                end
                if (i_cmd.op == OP_WRITE) begin
                    n_held_byte = i_cmd.byte_to_send;
                    n_phase     = PH_W_NOTBUSY;
                end else begin
                    n_phase = PH_R_NOTBUSY;
                end
            end
        end else begin
            case (r_phase)
                PH_I_PULSE: begin
                    if (r_ticks == '0) begin
                        n_phase = PH_I_RECOVER;
                        n_ticks = count_load(r_init_recover);
                    end else begin
                        n_ticks = r_ticks - TIMER_WIDTH'(1);
                    end
                end
                PH_I_RECOVER: begin
                    if (r_ticks == '0) begin
                        n_phase = PH_IDLE;
                        done    = 1'b1;
                    end else begin
                        n_ticks = r_ticks - TIMER_WIDTH'(1);
                    end
                end
                default: ;
            endcase
        end

        // One handshake wait, evaluated on the updated phase
        unique case (n_phase)
            PH_W_NOTBUSY: begin
                if (i_cmd.busy_off) begin
                    n_phase = PH_W_BUSY;
                end else if (n_expired) begin
                    n_phase = PH_IDLE; done = 1'b1; err = ERR_WRITE_TIME;
                end
            end
            PH_W_BUSY: begin
                if (!i_cmd.busy_off) begin
                    n_phase = PH_W_CLEAR;
                end else if (n_expired) begin
                    n_phase = PH_IDLE; done = 1'b1; err = ERR_WRITE_TIME;
                end
            end
            PH_W_CLEAR: begin
                if (i_cmd.busy_off && i_cmd.ack_off) begin
                    n_phase = PH_IDLE; done = 1'b1;
                end else if (n_expired) begin
                    n_phase = PH_IDLE; done = 1'b1; err = ERR_WRITE_TIME;
                end
            end
            PH_R_NOTBUSY: begin
                if (i_cmd.busy_off) begin
                    n_phase = PH_R_ACK;
                end else if (n_expired) begin
                    n_phase = PH_IDLE; done = 1'b1; err = ERR_READ_TIME;
                end
            end
            PH_R_ACK: begin
                if (!i_cmd.ack_off) begin
                    n_latched_byte = i_cmd.data_lines_in;
                    n_phase        = PH_R_ACKOFF;
                end else if (n_expired) begin
                    n_phase = PH_IDLE; done = 1'b1; err = ERR_READ_TIME;
                end
            end
            PH_R_ACKOFF: begin
                if (i_cmd.ack_off) begin
                    n_phase = PH_IDLE; done = 1'b1;
                end else if (n_expired) begin
                    n_phase = PH_IDLE; done = 1'b1; err = ERR_READ_TIME;
                end
            end
            PH_I_PULSE, PH_I_RECOVER, PH_IDLE: ;
            default: n_phase = PH_IDLE;
        endcase
    end

    // Result beat from the state after the tick
    always_comb begin
        n_out.strobe_on       = (n_phase == PH_W_BUSY) || (n_phase == PH_R_ACKOFF);
        n_out.autofd_on       = (n_phase == PH_R_ACK);
        n_out.init_on         = (n_phase == PH_I_PULSE);
        n_out.data_lines_out  = n_held_byte;
        n_out.lines_are_input = (n_phase == PH_R_NOTBUSY) || (n_phase == PH_R_ACK)
                                || (n_phase == PH_R_ACKOFF);
        n_out.engine_busy     = (n_phase != PH_IDLE);
        n_out.done_res        = done;
        n_out.error_code      = err;
        n_out.received_byte   = n_latched_byte;
    end

    // Engine state advances one step per consumed command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_ticks        <= '0;
            r_expired      <= 1'b0;
            r_held_byte    <= '0;
            r_latched_byte <= '0;
        end else if (step) begin
            r_phase        <= n_phase;
            r_ticks        <= n_ticks;
            r_expired      <= n_expired;
            r_held_byte    <= n_held_byte;
            r_latched_byte <= n_latched_byte;
        end
    end

    // Result register: load on a step, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // An error code only ever rides on a done beat
    a_err_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.error_code == ERR_OK || r_out.done_res))
        else $error("error code without done");

    // A printer reset always runs with the timer expiry flag cleared
    a_reset_no_expiry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_I_PULSE || r_phase == PH_I_RECOVER) |-> !r_expired)
        else $error("timer expired during printer reset");

    // The handshake phase moves only on a consumed command
    a_phase_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !step |=> $stable(r_phase))
        else $error("phase changed without a step");

    // The busy flag of a fresh result matches the engine phase
    a_busy_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> (r_out.engine_busy == (r_phase != PH_IDLE)))
        else $error("engine_busy out of step with phase");

endmodule

`default_nettype wire

/* hw/rtl/parallel_port_handshake_engine.sv */
// Top level of the parallel port handshake engine: front stage, command queue, back end.
// Depends on pphe_pkg, pphe_front, pphe_queue and pphe_back.
//
//   channel   direction  width  contents (lowest bit first)
//   s_axis    in         24+2   tdata: byte_to_send, first_of_buffer, busy_bit, ack_bit,
//                               data_lines_in; tuser: op
//   m_axis    out        24     tdata: strobe_on, autofd_on, init_on, data_lines_out,
//                               lines_are_input, engine_busy, done_res, error_code,
//                               received_byte
//   cfg       in         2+24   write enable, register index, write data
//
// One input beat per cycle is sustained while the output is not stalled; each beat gives
// exactly one result beat. Each beat passes the front register, the queue slot, and the
// engine step into the result register. The four-entry queue absorbs output stalls.
// Reset (i_rst_n low, synchronous) returns the engine to idle with the timer cleared.
`timescale 1ns / 1ps
`default_nettype none

module parallel_port_handshake_engine
    import pphe_pkg::*;
#(
    parameter int TIMER_WIDTH = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // byte_to_send[7:0], first_of_buffer[8], busy_bit[9], ack_bit[10],
    // data_lines_in[18:11], zero pad[23:19]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op[1:0]
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // strobe_on[0], autofd_on[1], init_on[2], data_lines_out[10:3],
    // lines_are_input[11], engine_busy[12], done_res[13], error_code[15:14],
    // received_byte[23:16]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_W-1:0]      i_cfg_wdata
);

    logic    front_valid;
    logic    front_ready;
    t_cmd    front_cmd;
    logic    queue_valid;
    logic    queue_ready;
    t_cmd    queue_cmd;
    t_cfg_wr cfg_wr;
    t_result result;

    // Bundle the configuration write
    assign cfg_wr.we   = i_cfg_we;
    assign cfg_wr.addr = i_cfg_addr;
    assign cfg_wr.data = i_cfg_wdata;

    pphe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_user  (s_axis_tuser),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_cmd   (front_cmd)
    );

    pphe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_cmd   (front_cmd),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_cmd    (queue_cmd)
    );

    pphe_back #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg_wr),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (queue_ready),
        .i_cmd       (queue_cmd),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out       (result)
    );

    assign m_axis_tdata = result;

endmodule

`default_nettype wire
